@@ rtl/core/olid_pkg.sv @@
package olid_pkg;

	localparam int CAPACITY_DEF = 16;
	localparam int WORD_W       = 32;
	// widest entry index, for capacities up to 64
	localparam int MAX_IDX_W    = 6;
	localparam int POS_W        = 4;

	typedef enum logic [2:0] {
		MD_INS_TAIL = 3'd0,
		MD_INS_HEAD = 3'd1,
		MD_INS_AT   = 3'd2,
		MD_DEL_AT   = 3'd3,
		MD_DEL_HEAD = 3'd4,
		MD_DEL_TAIL = 3'd5,
		MD_TRAVERSE = 3'd6
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_FULL   = 2'd1,
		ST_EMPTY  = 2'd2,
		ST_BADIDX = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SHIFT,
		S_TRAV
	} state_t;

	// one read port and one write port of the entry memory
	typedef struct packed {
		logic                     re;
		logic [MAX_IDX_W-1:0]     raddr;
		logic                     we;
		logic [MAX_IDX_W-1:0]     waddr;
		logic [WORD_W-1:0]        wdata;
	} mem_req_t;

endpackage

@@ rtl/core/ordered_list_insert_delete.sv @@
// Insert or delete: the single result goes to the pending register, then to the
// output register once that is free. The shift pass moves one entry per cycle
// through the entry memory's single read port; no new item is taken until the
// pass has ended and the pending result has moved on to the output register.
// Traverse: entries go in order to the output register, one per cycle while free.
// Reset clears the count and the handshake state; entry memory is not cleared.
module ordered_list_insert_delete #(
	parameter int CAPACITY = olid_pkg::CAPACITY_DEF,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [2:0]                         mode,
	input  logic signed [olid_pkg::WORD_W-1:0] value,
	input  logic [olid_pkg::POS_W-1:0]         position,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         status,
	output logic signed [olid_pkg::WORD_W-1:0] result_value,
	output logic [CW-1:0]                      entry_count,
	output logic                               last
);

	// request to, and read data from, the entry memory
	olid_pkg::mem_req_t          mem_req;
	logic [olid_pkg::WORD_W-1:0] mem_rdata;

	// sequencer: decode the item, run the shift or traverse pass, hold results
	olid_ctrl #(
		.CAPACITY (CAPACITY)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.value        (value),
		.position     (position),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.result_value (result_value),
		.entry_count  (entry_count),
		.last         (last),
		.mem_req      (mem_req),
		.mem_rdata    (mem_rdata)
	);

	// entry store: one read and one write a cycle, registered read data
	olid_mem #(
		.DEPTH (CAPACITY)
	) u_mem (
		.clk   (clk),
		.req   (mem_req),
		.rdata (mem_rdata)
	);

endmodule

@@ rtl/core/olid_mem.sv @@
module olid_mem #(
	parameter int DEPTH = olid_pkg::CAPACITY_DEF
) (
	input  logic                        clk,
	input  olid_pkg::mem_req_t          req,
	output logic [olid_pkg::WORD_W-1:0] rdata
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [olid_pkg::WORD_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[AW-1:0]] <= req.wdata;
		end
	end

	// read data holds while no read is issued
	always_ff @(posedge clk) begin
		if (req.re) begin
			rdata <= mem[req.raddr[AW-1:0]];
		end
	end

endmodule

@@ rtl/core/olid_ctrl.sv @@
module olid_ctrl #(
	parameter int CAPACITY = olid_pkg::CAPACITY_DEF,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [2:0]                         mode,
	input  logic signed [olid_pkg::WORD_W-1:0] value,
	input  logic [olid_pkg::POS_W-1:0]         position,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [1:0]                         status,
	output logic signed [olid_pkg::WORD_W-1:0] result_value,
	output logic [CW-1:0]                      entry_count,
	output logic                               last,
	output olid_pkg::mem_req_t                 mem_req,
	input  logic [olid_pkg::WORD_W-1:0]        mem_rdata
);

	localparam int IW = $clog2(CAPACITY);
	localparam int PW = CW + olid_pkg::POS_W;
	localparam int WW = olid_pkg::WORD_W;

	olid_pkg::state_t  state_q, state_d;
	logic [CW-1:0]     count_q;

	// pending single result, waiting for the output register
	logic              pend_q;
	olid_pkg::status_t pst_q;
	logic [WW-1:0]     pval_q;

	// output register
	logic              ovalid_q;
	olid_pkg::status_t ost_q;
	logic [WW-1:0]     oval_q;
	logic [CW-1:0]     ocnt_q;
	logic              olast_q;

	// shift sequencer
	logic              up_q;
	logic              rd_more_q;
	logic [IW-1:0]     src_q;
	logic [IW-1:0]     at_q;
	logic [WW-1:0]     w_q;
	logic              wr_valid_s1;
	logic [IW-1:0]     wr_addr_s1;

	// traverse
	logic [IW-1:0]     tidx_q;

	// accept decode
	logic              in_fire;
	logic              out_free;
	logic              cnt_full;
	logic              cnt_zero;
	logic              pos_ok;
	logic [CW-1:0]     at_c;
	logic              d_pend;
	olid_pkg::status_t d_st;
	logic [WW-1:0]     d_val;
	logic              d_shift;
	logic              d_up;
	logic              d_trav;
	logic              trav_last;
	logic              ld_pend;
	logic              ld_trav;

	assign in_ready = (state_q == olid_pkg::S_IDLE) && !pend_q;
	assign in_fire  = in_valid && in_ready;
	assign out_free = !ovalid_q || out_ready;
	assign cnt_full = (count_q == CW'(CAPACITY));
	assign cnt_zero = (count_q == '0);
	assign pos_ok   = (PW'(position) < PW'(count_q));
	assign trav_last = (tidx_q == IW'(count_q - CW'(1)));
	assign ld_pend  = pend_q && out_free;
	assign ld_trav  = (state_q == olid_pkg::S_TRAV) && out_free;

	always_comb begin
		d_pend  = 1'b0;
		d_st    = olid_pkg::ST_OK;
		d_val   = '0;
		d_shift = 1'b0;
		d_up    = 1'b0;
		d_trav  = 1'b0;
		at_c    = '0;
		case (olid_pkg::mode_t'(mode))
			olid_pkg::MD_INS_TAIL, olid_pkg::MD_INS_HEAD, olid_pkg::MD_INS_AT: begin
				d_pend = 1'b1;
				d_up   = 1'b1;
				if (mode == olid_pkg::MD_INS_TAIL) begin
					at_c = count_q;
				end else if (mode == olid_pkg::MD_INS_AT) begin
					at_c = CW'(PW'(position));
				end
				if (cnt_full) begin
					d_st = olid_pkg::ST_FULL;
				end else if (mode == olid_pkg::MD_INS_AT && !pos_ok) begin
					d_st = olid_pkg::ST_BADIDX;
				end else begin
					d_val   = value;
					d_shift = 1'b1;
				end
			end
			olid_pkg::MD_DEL_AT, olid_pkg::MD_DEL_HEAD, olid_pkg::MD_DEL_TAIL: begin
				d_pend = 1'b1;
				if (mode == olid_pkg::MD_DEL_AT) begin
					at_c = CW'(PW'(position));
				end else if (mode == olid_pkg::MD_DEL_TAIL) begin
					at_c = count_q - CW'(1);
				end
				if (cnt_zero) begin
					d_st = olid_pkg::ST_EMPTY;
				end else if (mode == olid_pkg::MD_DEL_AT && !pos_ok) begin
					d_st = olid_pkg::ST_BADIDX;
				end else begin
					d_val   = WW'(at_c);
					d_shift = 1'b1;
				end
			end
			olid_pkg::MD_TRAVERSE: begin
				if (cnt_zero) begin
					d_pend = 1'b1;
				end else begin
					d_trav = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			olid_pkg::S_IDLE: begin
				if (in_fire && d_shift) begin
					state_d = olid_pkg::S_SHIFT;
				end else if (in_fire && d_trav) begin
					state_d = olid_pkg::S_TRAV;
				end
			end
			olid_pkg::S_SHIFT: begin
				if (!rd_more_q && !wr_valid_s1) begin
					state_d = olid_pkg::S_IDLE;
				end
			end
			olid_pkg::S_TRAV: begin
				if (out_free && trav_last) begin
					state_d = olid_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = olid_pkg::S_IDLE;
			end
		endcase
	end

	// memory port
	always_comb begin
		mem_req = '0;
		case (state_q)
			olid_pkg::S_IDLE: begin
				if (in_fire && d_trav) begin
					mem_req.re = 1'b1;
				end
			end
			olid_pkg::S_SHIFT: begin
				if (rd_more_q) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = olid_pkg::MAX_IDX_W'(src_q);
				end
				if (wr_valid_s1) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = olid_pkg::MAX_IDX_W'(wr_addr_s1);
					mem_req.wdata = mem_rdata;
				end else if (!rd_more_q && up_q) begin
					mem_req.we    = 1'b1;
					mem_req.waddr = olid_pkg::MAX_IDX_W'(at_q);
					mem_req.wdata = w_q;
				end
			end
			olid_pkg::S_TRAV: begin
				if (out_free && !trav_last) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = olid_pkg::MAX_IDX_W'(tidx_q + IW'(1));
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= olid_pkg::S_IDLE;
			count_q     <= '0;
			pend_q      <= 1'b0;
			ovalid_q    <= 1'b0;
			rd_more_q   <= 1'b0;
			wr_valid_s1 <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_fire && d_shift) begin
				count_q   <= d_up ? count_q + CW'(1) : count_q - CW'(1);
				rd_more_q <= d_up ? (at_c < count_q) : ((at_c + CW'(1)) < count_q);
			end else if (state_q == olid_pkg::S_SHIFT && rd_more_q) begin
				rd_more_q <= up_q ? (src_q != at_q) : (src_q != IW'(count_q));
			end
			if (state_q == olid_pkg::S_SHIFT) begin
				wr_valid_s1 <= rd_more_q;
			end
			if (in_fire && d_pend) begin
				pend_q <= 1'b1;
			end else if (ld_pend) begin
				pend_q <= 1'b0;
			end
			if (ld_pend || ld_trav) begin
				ovalid_q <= 1'b1;
			end else if (out_ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	// payload and pointers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			pst_q  <= d_st;
			pval_q <= d_val;
			up_q   <= d_up;
			at_q   <= IW'(at_c);
			w_q    <= value;
			src_q  <= d_up ? IW'(count_q - CW'(1)) : IW'(at_c + CW'(1));
			tidx_q <= '0;
		end else if (state_q == olid_pkg::S_SHIFT && rd_more_q) begin
			src_q <= up_q ? src_q - IW'(1) : src_q + IW'(1);
		end else if (ld_trav && !trav_last) begin
			tidx_q <= tidx_q + IW'(1);
		end
		if (state_q == olid_pkg::S_SHIFT) begin
			wr_addr_s1 <= up_q ? src_q + IW'(1) : src_q - IW'(1);
		end
		if (ld_pend) begin
			ost_q   <= pst_q;
			oval_q  <= pval_q;
			ocnt_q  <= count_q;
			olast_q <= 1'b1;
		end else if (ld_trav) begin
			ost_q   <= olid_pkg::ST_OK;
			oval_q  <= mem_rdata;
			ocnt_q  <= count_q;
			olast_q <= trav_last;
		end
	end

	assign out_valid    = ovalid_q;
	assign status       = ost_q;
	assign result_value = oval_q;
	assign entry_count  = ocnt_q;
	assign last         = olast_q;

endmodule

@@ rtl/core/olid_checker.sv @@
module olid_checker #(
	parameter int CAPACITY = olid_pkg::CAPACITY_DEF,
	localparam int CW = $clog2(CAPACITY + 1)
) (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               out_valid,
	input logic                               out_ready,
	input logic [1:0]                         status,
	input logic signed [olid_pkg::WORD_W-1:0] result_value,
	input logic [CW-1:0]                      entry_count,
	input logic                               last
);

	// a stalled item holds its value and last flag
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(last))
		else $error("stalled item changed");

	// a rejected operation ends its item
	a_reject_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != olid_pkg::ST_OK |-> last)
		else $error("rejected item without last");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == olid_pkg::ST_FULL |-> entry_count == CW'(CAPACITY))
		else $error("full reported below capacity");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == olid_pkg::ST_EMPTY |-> entry_count == '0)
		else $error("empty reported with entries held");

	a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> entry_count <= CW'(CAPACITY))
		else $error("count beyond capacity");

endmodule

bind ordered_list_insert_delete olid_checker #(
	.CAPACITY (CAPACITY)
) u_olid_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.status       (status),
	.result_value (result_value),
	.entry_count  (entry_count),
	.last         (last)
);

@@ dv/tb_ordered_list_insert_delete.sv @@
module tb_ordered_list_insert_delete;

	localparam int LIST_CAP = olid_pkg::CAPACITY_DEF;
	localparam int CNT_W = $clog2(LIST_CAP + 1);
	// spare mode code: the block must drop it without a result
	localparam logic [2:0] MD_SPARE = 3'd7;
	localparam int HOLD_CYCLES = 200;
	localparam int WATCHDOG_LIMIT = 2000;
	// drain time grows with the capacity, for a shift pass or a traverse of a full
	// list: allow a safe margin
	localparam int DRAIN_CYCLES = 3 * LIST_CAP + 16;
	localparam int REPORT_MAX = 10;

	typedef struct {
		logic [1:0]       status;
		logic [31:0]      word;
		logic [CNT_W-1:0] held;
		logic             last;
	} list_result_t;

	// receiver stall patterns
	typedef enum {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_MOSTLY
	} rx_pattern_t;

	logic                               clk = 1'b0;
	logic                               arst_n = 1'b0;
	logic                               in_valid = 1'b0;
	logic                               in_ready;
	logic [2:0]                         mode = olid_pkg::MD_INS_TAIL;
	logic signed [olid_pkg::WORD_W-1:0] value = '0;
	logic [olid_pkg::POS_W-1:0]         position = '0;
	logic                               out_valid;
	logic                               out_ready = 1'b0;
	logic [1:0]                         status;
	logic signed [olid_pkg::WORD_W-1:0] result_value;
	logic [CNT_W-1:0]                   entry_count;
	logic                               last;

	// shadow copy of the list, advanced when each item is accepted
	logic [31:0]  list_words [LIST_CAP];
	int           list_len = 0;
	list_result_t awaited_results [$];

	int burst_left = 0;
	int hold_token = 0;
	int err_count = 0;
	int items_sent = 0;
	int spare_sent = 0;
	int traverses_sent = 0;
	int results_seen = 0;
	int status_tally [4] = '{0, 0, 0, 0};

	ordered_list_insert_delete uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.value        (value),
		.position     (position),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.result_value (result_value),
		.entry_count  (entry_count),
		.last         (last)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Work out the results of one accepted item and advance the shadow list.
	// Inserts check for a full list before the index; deletes check for an
	// empty list before the index. Rejections leave the list alone and give
	// a zero word.
	function automatic void predict_list_op(input logic [2:0] m, input logic [31:0] w,
			input logic [3:0] p);
		list_result_t r;
		int at;
		r.word = '0;
		r.last = 1'b1;
		case (m)
		olid_pkg::MD_INS_TAIL, olid_pkg::MD_INS_HEAD, olid_pkg::MD_INS_AT: begin
			if (list_len >= LIST_CAP) begin
				r.status = olid_pkg::ST_FULL;
			end else if (m == olid_pkg::MD_INS_AT && int'(p) >= list_len) begin
				r.status = olid_pkg::ST_BADIDX;
			end else begin
				at = (m == olid_pkg::MD_INS_TAIL) ? list_len
					: (m == olid_pkg::MD_INS_HEAD) ? 0 : int'(p);
				for (int i = list_len; i > at; i--)
					list_words[i] = list_words[i - 1];
				list_words[at] = w;
				list_len++;
				r.status = olid_pkg::ST_OK;
				r.word = w;
			end
			r.held = CNT_W'(list_len);
			awaited_results.push_back(r);
			status_tally[r.status]++;
		end
		olid_pkg::MD_DEL_AT, olid_pkg::MD_DEL_HEAD, olid_pkg::MD_DEL_TAIL: begin
			at = (m == olid_pkg::MD_DEL_AT) ? int'(p)
				: (m == olid_pkg::MD_DEL_HEAD) ? 0 : list_len - 1;
			if (list_len == 0) begin
				r.status = olid_pkg::ST_EMPTY;
			end else if (at >= list_len) begin
				r.status = olid_pkg::ST_BADIDX;
			end else begin
				for (int i = at + 1; i < list_len; i++)
					list_words[i - 1] = list_words[i];
				list_len--;
				r.status = olid_pkg::ST_OK;
				r.word = 32'(at);
			end
			r.held = CNT_W'(list_len);
			awaited_results.push_back(r);
			status_tally[r.status]++;
		end
		olid_pkg::MD_TRAVERSE: begin
			// an empty list still answers once, with a zero word
			if (list_len == 0) begin
				r.status = olid_pkg::ST_OK;
				r.held = '0;
				awaited_results.push_back(r);
			end
			for (int i = 0; i < list_len; i++) begin
				r.status = olid_pkg::ST_OK;
				r.word = list_words[i];
				r.held = CNT_W'(list_len);
				r.last = (i == list_len - 1);
				awaited_results.push_back(r);
			end
		end
		default: ;
		endcase
	endfunction

	// Offer one item and hold it until accepted. Items go out in bursts of
	// random length; between bursts valid drops for a random gap, now and then none.
	task automatic offer_item(input logic [2:0] m, input logic [31:0] w, input logic [3:0] p);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			// now and then a long burst, so some stretches run without gaps
			burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
				: $urandom_range(1, 10);
		end
		in_valid <= 1'b1;
		mode <= m;
		value <= w;
		position <= p;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predict_list_op(m, w, p);
		if (m == MD_SPARE)
			spare_sent++;
		else
			items_sent++;
		if (m == olid_pkg::MD_TRAVERSE)
			traverses_sent++;
		burst_left--;
	endtask

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
		0: return 32'h8000_0000;
		1: return 32'h7fff_ffff;
		2: return 32'h0000_0000;
		3: return 32'hffff_ffff;
		default: return $urandom();
		endcase
	endfunction

	// mostly an index that holds an entry, sometimes any index at all
	function automatic logic [3:0] pick_position();
		if (list_len > 0 && $urandom_range(0, 4) != 0)
			return 4'($urandom_range(0, list_len - 1));
		return 4'($urandom_range(0, 15));
	endfunction

	// Every kind of rejection on an empty list, the empty traverse and the
	// spare mode.
	task automatic test_empty_list();
		offer_item(olid_pkg::MD_TRAVERSE, 32'h1234_5678, 4'd0);
		offer_item(olid_pkg::MD_DEL_AT, 32'h0, 4'd0);
		offer_item(olid_pkg::MD_DEL_HEAD, 32'h0, 4'd15);
		offer_item(olid_pkg::MD_DEL_TAIL, 32'hffff_ffff, 4'd0);
		offer_item(olid_pkg::MD_INS_AT, 32'h5a5a_a5a5, 4'd0);
		offer_item(MD_SPARE, 32'hdead_beef, 4'd9);
	endtask

	// Extreme words at head, tail and mid-list, index edges on both sides.
	task automatic test_edge_words();
		offer_item(olid_pkg::MD_INS_TAIL, 32'h7fff_ffff, 4'd15);
		offer_item(olid_pkg::MD_INS_HEAD, 32'h8000_0000, 4'd15);
		offer_item(olid_pkg::MD_INS_AT, 32'h0000_0000, 4'd1);
		offer_item(olid_pkg::MD_INS_AT, 32'h1111_1111, 4'd3);
		offer_item(olid_pkg::MD_INS_TAIL, 32'hffff_ffff, 4'd0);
		offer_item(olid_pkg::MD_TRAVERSE, 32'h0, 4'd0);
		offer_item(olid_pkg::MD_DEL_AT, 32'h0, 4'd15);
		offer_item(olid_pkg::MD_DEL_AT, 32'h0, 4'd2);
		offer_item(olid_pkg::MD_DEL_HEAD, 32'h0, 4'd0);
		offer_item(olid_pkg::MD_DEL_TAIL, 32'h0, 4'd0);
		offer_item(olid_pkg::MD_DEL_AT, 32'h0, 4'd0);
	endtask

	// Fill with random inserts, then try every insert on the full list and
	// list it.
	task automatic test_fill_to_full();
		logic [2:0] m;
		while (list_len < LIST_CAP) begin
			m = 3'(olid_pkg::MD_INS_TAIL + $urandom_range(0, 2));
			if (m == olid_pkg::MD_INS_AT && list_len == 0)
				m = olid_pkg::MD_INS_HEAD;
			offer_item(m, pick_word(), pick_position());
		end
		offer_item(olid_pkg::MD_INS_TAIL, 32'h0, 4'd0);
		offer_item(olid_pkg::MD_INS_HEAD, 32'hffff_ffff, 4'd15);
		offer_item(olid_pkg::MD_INS_AT, 32'h8000_0000, 4'd15);
		offer_item(olid_pkg::MD_TRAVERSE, 32'h0, 4'd0);
	endtask

	// Stall the receiver for a long stretch while items keep coming, so the
	// block backs up and drops in_ready. A traverse of a full list goes first.
	task automatic test_output_backpressure();
		hold_token <= hold_token + 1;
		burst_left = 30;
		offer_item(olid_pkg::MD_TRAVERSE, 32'h0, 4'd0);
		offer_item(olid_pkg::MD_DEL_AT, 32'h0, 4'(LIST_CAP - 1));
		// list now one short of full: this index lies just past the tail
		offer_item(olid_pkg::MD_INS_AT, 32'h0bad_0bad, 4'(LIST_CAP - 1));
		offer_item(olid_pkg::MD_INS_TAIL, $urandom(), 4'd0);
		offer_item(olid_pkg::MD_DEL_HEAD, 32'h0, 4'd0);
		offer_item(olid_pkg::MD_TRAVERSE, 32'h0, 4'd0);
		offer_item(olid_pkg::MD_INS_HEAD, $urandom(), 4'd0);
	endtask

	// Random walk over the list: grow_pct sets how often an insert is picked
	// over a delete. Traverses and spare codes are mixed in; spare codes do
	// not count towards the item total.
	task automatic test_random_walk(input int n_items, input int grow_pct);
		int done;
		int roll;
		logic [2:0] m;
		done = 0;
		while (done < n_items) begin
			roll = $urandom_range(0, 99);
			if (roll < 3)
				m = MD_SPARE;
			else if (roll < 11)
				m = olid_pkg::MD_TRAVERSE;
			else if ($urandom_range(0, 99) < grow_pct)
				m = 3'(olid_pkg::MD_INS_TAIL + $urandom_range(0, 2));
			else
				m = 3'(olid_pkg::MD_DEL_AT + $urandom_range(0, 2));
			offer_item(m, pick_word(), pick_position());
			if (m != MD_SPARE)
				done++;
		end
	endtask

	// Receiver: a long hold-off when asked for, otherwise a random stall pattern that
	// is picked anew whenever its timer runs out.
	int          hold_seen = 0;
	int          hold_left = 0;
	int          rx_timer = 0;
	rx_pattern_t rx_pattern = RX_OPEN;

	always @(posedge clk) begin
		if (hold_seen != hold_token) begin
			hold_seen = hold_token;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (rx_timer == 0) begin
				rx_pattern = rx_pattern_t'($urandom_range(0, 3));
				rx_timer = $urandom_range(20, 80);
			end
			rx_timer--;
			case (rx_pattern)
			RX_OPEN: out_ready <= 1'b1;
			RX_COIN: out_ready <= 1'($urandom_range(0, 1));
			RX_SPARSE: out_ready <= (rx_timer % 4 == 0);
			default: out_ready <= ($urandom_range(0, 3) != 0);
			endcase
		end
	end

	function automatic void note_failure(input string what);
		err_count++;
		if (err_count <= REPORT_MAX)
			$display("ERROR @%0t: %s", $time, what);
	endfunction

	// Compare each result taken from the block against the oldest awaited one.
	always @(posedge clk) begin
		list_result_t want;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (awaited_results.size() == 0) begin
				note_failure($sformatf("unexpected result st=%0d val=%h cnt=%0d last=%b",
					status, result_value, entry_count, last));
			end else begin
				want = awaited_results.pop_front();
				if (status !== want.status || result_value !== want.word
						|| entry_count !== want.held || last !== want.last)
					note_failure($sformatf(
						"result %0d: expected st=%0d val=%h cnt=%0d last=%b, got st=%0d val=%h cnt=%0d last=%b",
						results_seen, want.status, want.word, want.held, want.last,
						status, result_value, entry_count, last));
			end
		end
	end

	// Watchdog: end the run if no handshake happens on either side for too long.
	int quiet_cycles = 0;

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("watchdog: no item moved for %0d cycles, %0d results still awaited",
					WATCHDOG_LIMIT, awaited_results.size());
				$display("tb: failure");
				$finish;
			end
		end
	end

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_empty_list();
		test_edge_words();
		test_random_walk(95, 70);
		test_fill_to_full();
		test_output_backpressure();
		test_random_walk(95, 30);
		test_random_walk(95, 50);

		in_valid <= 1'b0;
		// drain, then give the block time to show any stray result
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("run: %0d items (%0d traverses) plus %0d spare-mode items, %0d results checked",
			items_sent, traverses_sent, spare_sent, results_seen);
		$display("run: rejections seen - full %0d, empty %0d, bad index %0d; %0d mismatches",
			status_tally[olid_pkg::ST_FULL], status_tally[olid_pkg::ST_EMPTY],
			status_tally[olid_pkg::ST_BADIDX], err_count);
		if (err_count == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
